/* hdl/ffbp_pkg.sv */
package ffbp_pkg;

  localparam int NUM_BINS_DEFAULT = 1024;
  localparam int SIZE_W           = 32;
  localparam int BIN_INDEX_W      = 10;
  localparam int BINS_USED_W      = 11;
  localparam int CMD_W            = 1;

  localparam logic [CMD_W-1:0] CMD_PLACE = 1'b0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 1'b1;

  localparam logic [SIZE_W-1:0] CAPACITY_RESET = {SIZE_W{1'b1}};

endpackage

/* hdl/first_fit_bin_packer_core.sv */
// First-fit bin packer over NUM_BINS bins. A place transaction clamps its size to
// the configured capacity and returns the lowest-indexed bin with enough room,
// subtracting the size from it; if no bin fits, overflow is set and nothing
// changes. The rooms live as a max segment tree in one single-port-read memory,
// and the leaves are the bins themselves. A place does one memory read per
// level on the way down and one sibling read plus parent write per level on
// the way back up. A clear transaction sweeps the whole tree memory, one entry
// a cycle, and its result is registered from the finish state once the sweep
// ends and the output is free. The next input transaction is taken once the
// result register has been loaded, so a stalled result holds off the input.
// After reset the same sweep runs with full capacity, and no input transaction
// is accepted until it ends; configuration writes are taken at any time and
// only affect later clamps and clears.
module first_fit_bin_packer_core #(
  parameter int NUM_BINS = ffbp_pkg::NUM_BINS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ffbp_pkg::SIZE_W-1:0]        cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [ffbp_pkg::CMD_W-1:0]         cmd,
  input  logic [ffbp_pkg::SIZE_W-1:0]        place_size,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ffbp_pkg::BIN_INDEX_W-1:0]   bin_index,
  output logic                               overflow,
  output logic [ffbp_pkg::BINS_USED_W-1:0]   bins_used
);

  import ffbp_pkg::*;

  localparam int BW = $clog2(NUM_BINS);
  localparam int NW = BW + 1;
  localparam int OW = BW + 1;
  localparam logic [BW-1:0] LAST_BIN = BW'(NUM_BINS - 1);
  localparam logic [NW-1:0] LAST_NODE = {NW{1'b1}};
  localparam logic [NW-1:0] ROOT = '0;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_ROOT   = 3'd2;
  localparam logic [2:0] S_DESC   = 3'd3;
  localparam logic [2:0] S_LEAF   = 3'd4;
  localparam logic [2:0] S_UP     = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0]        state, state_next;
  logic [SIZE_W-1:0] capacity;
  logic [SIZE_W-1:0] fill_val, fill_val_next;
  logic [NW-1:0]     clr_addr, clr_addr_next;
  logic              clr_resp, clr_resp_next;
  logic [SIZE_W-1:0] size, size_next;
  logic [NW-1:0]     node, node_next;
  logic [BW-1:0]     lo, lo_next;
  logic [BW-1:0]     hi, hi_next;
  logic [SIZE_W-1:0] cur_val, cur_val_next;
  logic [OW-1:0]     open_bins, open_bins_next;
  logic [BW-1:0]     res_bin, res_bin_next;
  logic              res_ovf, res_ovf_next;

  logic              rd_en, wr_en;
  logic [NW-1:0]     rd_addr, wr_addr;
  logic [SIZE_W-1:0] rd_data, wr_data;

  logic [BW-1:0]     mid;
  logic              go_left;
  logic [NW-1:0]     child_node;
  logic [BW-1:0]     child_lo, child_hi;
  logic [NW-1:0]     sibling, parent;
  logic [NW-1:0]     parent_sibling;
  logic [SIZE_W-1:0] up_max;
  logic              out_free;
  logic [31:0]       bin_wide, open_wide;

  ffbp_tree_mem #(
    .ADDR_W (NW),
    .DATA_W (SIZE_W)
  ) u_tree_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;

  assign mid        = lo + ((hi - lo) >> 1);
  assign go_left    = (rd_data >= size);
  assign child_node = go_left ? NW'((node << 1) + 1'b1) : NW'((node << 1) + 2'd2);
  assign child_lo   = go_left ? lo : BW'(mid + 1'b1);
  assign child_hi   = go_left ? mid : hi;

  // Left children have odd heap indexes.
  assign sibling        = node[0] ? NW'(node + 1'b1) : NW'(node - 1'b1);
  assign parent         = NW'((node - 1'b1) >> 1);
  assign parent_sibling = parent[0] ? NW'(parent + 1'b1) : NW'(parent - 1'b1);
  assign up_max         = (rd_data > cur_val) ? rd_data : cur_val;

  always_comb begin
    state_next     = state;
    fill_val_next  = fill_val;
    clr_addr_next  = clr_addr;
    clr_resp_next  = clr_resp;
    size_next      = size;
    node_next      = node;
    lo_next        = lo;
    hi_next        = hi;
    cur_val_next   = cur_val;
    open_bins_next = open_bins;
    res_bin_next   = res_bin;
    res_ovf_next   = res_ovf;
    rd_en          = 1'b0;
    rd_addr        = ROOT;
    wr_en          = 1'b0;
    wr_addr        = ROOT;
    wr_data        = rd_data;

    unique case (state)
      S_CLEAR: begin
        wr_en         = 1'b1;
        wr_addr       = clr_addr;
        wr_data       = fill_val;
        clr_addr_next = NW'(clr_addr + 1'b1);
        if (clr_addr == LAST_NODE) begin
          open_bins_next = '0;
          res_bin_next   = '0;
          res_ovf_next   = 1'b0;
          state_next     = clr_resp ? S_FINISH : S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          if (cmd == CMD_CLEAR) begin
            fill_val_next = capacity;
            clr_addr_next = '0;
            clr_resp_next = 1'b1;
            state_next    = S_CLEAR;
          end else begin
            size_next  = (place_size > capacity) ? capacity : place_size;
            node_next  = ROOT;
            lo_next    = '0;
            hi_next    = LAST_BIN;
            rd_en      = 1'b1;
            rd_addr    = ROOT;
            state_next = S_ROOT;
          end
        end
      end

      S_ROOT: begin
        if (rd_data < size) begin
          res_bin_next = '0;
          res_ovf_next = 1'b1;
          state_next   = S_FINISH;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = NW'((node << 1) + 1'b1);
          state_next = S_DESC;
        end
      end

      S_DESC: begin
        node_next = child_node;
        lo_next   = child_lo;
        hi_next   = child_hi;
        rd_en     = 1'b1;
        if (child_lo == child_hi) begin
          rd_addr    = child_node;
          state_next = S_LEAF;
        end else begin
          rd_addr = NW'((child_node << 1) + 1'b1);
        end
      end

      S_LEAF: begin
        if (rd_data >= size) begin
          wr_en        = 1'b1;
          wr_addr      = node;
          wr_data      = rd_data - size;
          cur_val_next = rd_data - size;
          res_bin_next = lo;
          res_ovf_next = 1'b0;
          if (OW'(lo) >= open_bins) begin
            open_bins_next = OW'(lo) + 1'b1;
          end
          rd_en      = 1'b1;
          rd_addr    = sibling;
          state_next = S_UP;
        end else begin
          res_bin_next = '0;
          res_ovf_next = 1'b1;
          state_next   = S_FINISH;
        end
      end

      S_UP: begin
        // The sibling read of the next level overlaps the parent write.
        wr_en        = 1'b1;
        wr_addr      = parent;
        wr_data      = up_max;
        cur_val_next = up_max;
        node_next    = parent;
        if (parent == ROOT) begin
          state_next = S_FINISH;
        end else begin
          rd_en   = 1'b1;
          rd_addr = parent_sibling;
        end
      end

      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      capacity  <= CAPACITY_RESET;
      fill_val  <= CAPACITY_RESET;
      clr_addr  <= '0;
      clr_resp  <= 1'b0;
      open_bins <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      fill_val  <= fill_val_next;
      clr_addr  <= clr_addr_next;
      clr_resp  <= (state == S_FINISH) ? 1'b0 : clr_resp_next;
      open_bins <= open_bins_next;
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    size    <= size_next;
    node    <= node_next;
    lo      <= lo_next;
    hi      <= hi_next;
    cur_val <= cur_val_next;
    res_bin <= res_bin_next;
    res_ovf <= res_ovf_next;
  end

  assign bin_wide  = 32'(res_bin);
  assign open_wide = 32'(open_bins);

  always_ff @(posedge clk) begin
    if (state == S_FINISH && out_free) begin
      bin_index <= bin_wide[BIN_INDEX_W-1:0];
      overflow  <= res_ovf;
      bins_used <= open_wide[BINS_USED_W-1:0];
    end
  end

endmodule

/* hdl/ffbp_tree_mem.sv */
module ffbp_tree_mem #(
  parameter int ADDR_W = 11,
  parameter int DATA_W = ffbp_pkg::SIZE_W
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  localparam int DEPTH = 2 ** ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
